// ===== rtl/srtf_pkg.sv =====
// Shared types and constants for the SRTF scheduler.
// No dependencies; srtf_ctrl, srtf_dp and the top level import this package.
`default_nettype none

package srtf_pkg;

  localparam int SLOT_W  = 5;
  localparam int FIELD_W = 16;
  localparam int T_W     = 22;
  localparam int CNT_W   = 6;

  localparam logic [T_W-1:0]   T_MAX       = '1;
  localparam logic [CNT_W-1:0] COUNT_RESET = 6'd1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] arrival_time;
    logic [FIELD_W-1:0] burst_length;
  } req_item_t;

  typedef struct packed {
    logic              ran;
    logic [SLOT_W-1:0] served_slot;
    logic              finished;
    logic [T_W-1:0]    completion_time;
    logic [T_W-1:0]    turnaround;
    logic [T_W-1:0]    waiting;
    logic [T_W-1:0]    response;
    logic              all_done;
  } rsp_item_t;

  typedef logic [CNT_W-1:0] cfg_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic fetch;
    logic update;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/srtf_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
// Used by the scheduler top level for its request, result and config ports.
`default_nettype none

interface srtf_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/srtf_ctrl.sv =====
// Sequencer for the SRTF scheduler: accepts items, steps the datapath
// through scan, fetch and update, and owns the result valid flag. Uses srtf_pkg.
`default_nettype none

module srtf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_kind,
  output logic              req_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  srtf_pkg::dp_sts_t sts,
  output srtf_pkg::dp_cmd_t cmd
);
  import srtf_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = (state == ST_IDLE) && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_kind == KIND_TICK) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready      = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        req_ready      = 1'b1;
        cmd.load       = accept && (req_kind == KIND_LOAD);
        cmd.scan_start = accept && (req_kind == KIND_TICK);
      end
      ST_FETCH:  cmd.fetch  = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_EMIT:   cmd.emit   = !out_valid || out_ready;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // Hold the result until taken; a new one may replace it in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srtf_dp.sv =====
// Datapath of the SRTF scheduler: slot tables, done flags, time, the
// one-slot-per-cycle minimum scan and the completion arithmetic. Uses srtf_pkg.
`default_nettype none

module srtf_dp #(
  parameter int MAX_PROCESSES = 32,
  parameter int TIME_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  srtf_pkg::dp_cmd_t   cmd,
  output srtf_pkg::dp_sts_t   sts,
  input  logic                cfg_wr,
  input  srtf_pkg::cfg_item_t cfg_data,
  input  srtf_pkg::req_item_t req_data,
  output srtf_pkg::rsp_item_t rsp_data
);
  import srtf_pkg::*;

  localparam int AW = $clog2(MAX_PROCESSES);
  localparam int NW = $clog2(MAX_PROCESSES + 1);

  typedef logic [TIME_BITS-1:0] tval_t;

  function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
    sub_sat = (a > b) ? (a - b) : 32'd0;
  endfunction

  // Slot tables
  tval_t          arrival_mem [MAX_PROCESSES];
  tval_t          burst_mem   [MAX_PROCESSES];
  tval_t          remain_mem  [MAX_PROCESSES];
  logic [T_W-1:0] start_mem   [MAX_PROCESSES];

  logic [MAX_PROCESSES-1:0] done;
  logic [CNT_W-1:0]         process_count;
  logic [T_W-1:0]           cur_time;

  logic [NW-1:0] n_act;
  logic [NW-1:0] issue_idx;
  logic [NW-1:0] done_cnt;
  logic          scanning;
  logic          issuing;
  logic          q_valid;
  logic [AW-1:0] q_idx;
  tval_t         arr_q;
  tval_t         burst_q;
  tval_t         rem_q;

  logic          best_found;
  logic [AW-1:0] best_idx;
  tval_t         best_arr;
  tval_t         best_burst;
  tval_t         best_rem;
  logic [T_W-1:0] start_q;

  logic          load_ok;
  logic [AW-1:0] load_addr;
  tval_t         load_arr;
  tval_t         load_burst;

  logic          eligible;
  logic          better;
  logic          all_pre;
  logic          upd_act;
  logic          first;
  tval_t         new_rem;
  logic          fin;
  logic [T_W-1:0] time_next;
  logic [T_W-1:0] start_val;
  logic [31:0]   tat32;
  logic [31:0]   wait32;
  logic [31:0]   resp32;
  rsp_item_t     res;
  rsp_item_t     res_next;

  assign load_ok    = 32'(req_data.slot) < MAX_PROCESSES;
  assign load_addr  = AW'(req_data.slot);
  assign load_arr   = TIME_BITS'(req_data.arrival_time);
  assign load_burst = TIME_BITS'(req_data.burst_length);

  assign n_act = (32'(process_count) > MAX_PROCESSES) ? NW'(MAX_PROCESSES)
                                                      : NW'(process_count);

  assign issuing       = scanning && (issue_idx < n_act);
  assign sts.scan_done = scanning && !issuing && !q_valid;

  // Table memories: one write port each, registered reads
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      arrival_mem[load_addr] <= load_arr;
      burst_mem[load_addr]   <= load_burst;
    end
    arr_q   <= arrival_mem[issue_idx[AW-1:0]];
    burst_q <= burst_mem[issue_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      remain_mem[load_addr] <= load_burst;
    end else if (cmd.update && upd_act) begin
      remain_mem[best_idx] <= new_rem;
    end
    rem_q <= remain_mem[issue_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.update && upd_act && first) begin
      start_mem[best_idx] <= cur_time;
    end
    if (cmd.fetch) begin
      start_q <= start_mem[best_idx];
    end
  end

  // Scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      q_valid  <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scanning <= 1'b1;
      end else if (sts.scan_done) begin
        scanning <= 1'b0;
      end
      q_valid <= issuing;
    end
  end

  assign eligible = q_valid && !done[q_idx] && (32'(arr_q) <= 32'(cur_time));
  assign better   = !best_found || (rem_q < best_rem) ||
                    ((rem_q == best_rem) && (arr_q < best_arr));

  // Running minimum; strict compares keep the lower slot on a full tie
  always_ff @(posedge clk) begin
    q_idx <= issue_idx[AW-1:0];
    if (cmd.scan_start) begin
      issue_idx  <= '0;
      done_cnt   <= '0;
      best_found <= 1'b0;
    end else begin
      if (issuing) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (q_valid) begin
        done_cnt <= done_cnt + NW'(done[q_idx]);
      end
      if (eligible && better) begin
        best_found <= 1'b1;
        best_idx   <= q_idx;
        best_arr   <= arr_q;
        best_burst <= burst_q;
        best_rem   <= rem_q;
      end
    end
  end

  assign all_pre   = done_cnt >= n_act;
  assign upd_act   = !all_pre && best_found;
  assign first     = best_rem == best_burst;
  assign new_rem   = (best_rem == '0) ? '0 : best_rem - 1'b1;
  assign fin       = new_rem == '0;
  assign time_next = (cur_time == T_MAX) ? cur_time : cur_time + 1'b1;
  assign start_val = first ? cur_time : start_q;
  assign tat32     = sub_sat(32'(time_next), 32'(best_arr));
  assign wait32    = sub_sat(tat32, 32'(best_burst));
  assign resp32    = sub_sat(32'(start_val), 32'(best_arr));

  always_comb begin
    res_next = '0;
    if (all_pre) begin
      res_next.all_done = 1'b1;
    end else begin
      if (upd_act) begin
        res_next.ran         = 1'b1;
        res_next.served_slot = SLOT_W'(best_idx);
        if (fin) begin
          res_next.finished        = 1'b1;
          res_next.completion_time = time_next;
          res_next.turnaround      = tat32[T_W-1:0];
          res_next.waiting         = wait32[T_W-1:0];
          res_next.response        = resp32[T_W-1:0];
        end
      end
      res_next.all_done = (32'(done_cnt) + 32'(upd_act && fin)) >= 32'(n_act);
    end
  end

  // Done flags, time and the slot count register
  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= '0;
      cur_time      <= '0;
      process_count <= COUNT_RESET;
    end else begin
      if (cfg_wr) begin
        process_count <= cfg_data;
      end
      if (cmd.load && load_ok) begin
        done[load_addr] <= 1'b0;
      end
      if (cmd.update && !all_pre) begin
        cur_time <= time_next;
        if (upd_act && fin) begin
          done[best_idx] <= 1'b1;
        end
      end
    end
  end

  // Staged result, then the output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= '0;
    end else if (cmd.update) begin
      res <= res_next;
    end
    if (cmd.emit) begin
      rsp_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srtf_preemptive_scheduler.sv =====
// Top level of the preemptive shortest-remaining-time-first scheduler.
// Joins srtf_ctrl and srtf_dp; uses srtf_pkg and srtf_stream_if.
//
//   Channel  Modport  Payload      Role
//   req      sink     req_item_t   load a slot or advance one tick
//   rsp      source   rsp_item_t   one result per request item
//   cfg      sink     cfg_item_t   process_count write, always ready
//
// A load writes its slot at accept and then emits; a tick scans the n active
// slots (process_count capped at MAX_PROCESSES), compares the reads, then
// fetches, updates and emits the result before the next item is accepted.
// rst clears the sequencer, done flags, time and sets process_count to 1;
// the slot tables hold garbage until loaded. A new item is accepted while
// a result still waits on rsp; a stalled rsp holds the next result back.
`default_nettype none

module srtf_preemptive_scheduler #(
  parameter int MAX_PROCESSES = 32,
  parameter int TIME_BITS     = 16
) (
  input  logic          clk,
  input  logic          rst,
  srtf_stream_if.sink   req,
  srtf_stream_if.source rsp,
  srtf_stream_if.sink   cfg
);
  import srtf_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      req_ready;
  logic      out_valid;
  rsp_item_t rsp_data;

  srtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.data.kind),
    .req_ready (req_ready),
    .out_ready (rsp.ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  srtf_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_wr   (cfg.valid),
    .cfg_data (cfg.data),
    .req_data (req.data),
    .rsp_data (rsp_data)
  );

  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = rsp_data;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an item is in progress");

  a_update_after_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $past(cmd.fetch))
    else $error("update without a preceding fetch");

  a_finish_needs_run: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.finished |-> rsp.data.ran)
    else $error("finished reported without a served slot");

  a_wait_le_tat: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.finished |-> rsp.data.waiting <= rsp.data.turnaround)
    else $error("waiting exceeds turnaround");

endmodule

`default_nettype wire
